/* rtl/rpu8_pkg.sv */
package rpu8_pkg;

	// Extra range rule for the next continuation byte
	localparam logic [2:0] LIM_NONE  = 3'd0;
	localparam logic [2:0] LIM_GE_A0 = 3'd1;
	localparam logic [2:0] LIM_LT_A0 = 3'd2;
	localparam logic [2:0] LIM_GE_90 = 3'd3;
	localparam logic [2:0] LIM_LT_90 = 3'd4;

	localparam logic [7:0] CHR_NUL       = 8'h00;
	localparam logic [7:0] CHR_SLASH     = 8'h2F;
	localparam logic [7:0] CHR_BACKSLASH = 8'h5C;
	localparam logic [7:0] CHR_DOT       = 8'h2E;

	localparam logic [7:0] ASCII_MAX  = 8'h7F;
	localparam logic [7:0] CONT_MASK  = 8'hC0;
	localparam logic [7:0] CONT_TAG   = 8'h80;
	localparam logic [7:0] LEAD2_MIN  = 8'hC2;
	localparam logic [7:0] LEAD2_MAX  = 8'hDF;
	localparam logic [7:0] LEAD3_MIN  = 8'hE0;
	localparam logic [7:0] LEAD3_MAX  = 8'hEF;
	localparam logic [7:0] LEAD3_SURR = 8'hED;
	localparam logic [7:0] LEAD4_MIN  = 8'hF0;
	localparam logic [7:0] LEAD4_MAX  = 8'hF4;
	localparam logic [7:0] BOUND_A0   = 8'hA0;
	localparam logic [7:0] BOUND_90   = 8'h90;

	localparam logic [1:0] SEG_LEN_MAX = 2'd3;

	typedef struct packed {
		logic [1:0] pending;
		logic [2:0] limit;
	} u8_state_t;

	typedef struct packed {
		logic [1:0] len;
		logic       all_dots;
	} seg_state_t;

endpackage

/* rtl/relative_path_utf8_checker_top.sv */
// A path's verdict is registered onto path_ok as its last item leaves the input register.
// Throughput: one item per cycle while in_stall is low.
// A stalled verdict holds; items without end keep advancing, and the next end item waits
// in the input register, stalling the input until the verdict is taken.
// Reset (arst_n low, asynchronous): empties the input and output registers and
// returns the path state to its start: no pending continuation, empty segment, not failed.
module relative_path_utf8_checker_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] path_byte,
	input  logic       has_byte,
	input  logic       end_of_path,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       path_ok
);

	// Input register: holds one accepted transaction
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       has_s1;
	logic       last_s1;

	// Per-path state
	rpu8_pkg::u8_state_t  u8_q;
	rpu8_pkg::seg_state_t seg_q;
	logic                 failed_q;

	// Result register
	logic out_valid_q;
	logic path_ok_q;

	rpu8_pkg::u8_state_t  u8_step;
	rpu8_pkg::seg_state_t seg_nxt;
	logic                 u8_bad;
	logic                 seg_bad;
	rpu8_pkg::u8_state_t  u8_nxt;
	logic                 failed_nxt;
	logic                 fire_s1;
	logic                 accept_in;

	rpu8_utf8 u_utf8 (
		.data (byte_s1),
		.cur  (u8_q),
		.nxt  (u8_step),
		.bad  (u8_bad)
	);

	rpu8_seg u_seg (
		.data     (byte_s1),
		.has_data (has_s1),
		.is_last  (last_s1),
		.cur      (seg_q),
		.nxt      (seg_nxt),
		.bad      (seg_bad)
	);

	// An item without end always advances; an end item needs room in the result register.
	assign fire_s1   = valid_s1 && (!last_s1 || !out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !fire_s1;
	assign accept_in = in_valid && !in_stall;

	// Merge the UTF-8 and path checks; an item without a byte leaves UTF-8 state alone.
	always_comb begin
		u8_nxt     = has_s1 ? u8_step : u8_q;
		failed_nxt = failed_q || (has_s1 && u8_bad) || seg_bad;
		// sequence cut short by the end
		if (last_s1 && (u8_nxt.pending != 2'd0))
			failed_nxt = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept_in) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept_in) begin
			byte_s1 <= path_byte;
			has_s1  <= has_byte;
			last_s1 <= end_of_path;
		end
	end

	// Advance the path state; drop back to the start state after each end.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			u8_q.pending  <= 2'd0;
			u8_q.limit    <= rpu8_pkg::LIM_NONE;
			seg_q.len     <= 2'd0;
			seg_q.all_dots <= 1'b1;
			failed_q      <= 1'b0;
		end else if (fire_s1) begin
			if (last_s1) begin
				u8_q.pending  <= 2'd0;
				u8_q.limit    <= rpu8_pkg::LIM_NONE;
				failed_q      <= 1'b0;
			end else begin
				u8_q     <= u8_nxt;
				failed_q <= failed_nxt;
			end
			seg_q <= seg_nxt;
		end
	end

	// Result register: load on an end item, hold while stalled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && last_s1) begin
			path_ok_q <= !failed_nxt;
		end
	end

	assign out_valid = out_valid_q;
	assign path_ok   = path_ok_q;

	// Input backs up only behind a stalled verdict
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid_q && out_stall && last_s1))
		else $error("input stalled without a waiting verdict");

	// After an end the path state is back at its start
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && last_s1) |=> ((u8_q.pending == 2'd0) && (u8_q.limit == rpu8_pkg::LIM_NONE)
			&& !failed_q && (seg_q.len == 2'd0) && seg_q.all_dots))
		else $error("path state not cleared after end of path");

	// A range rule only exists right after a three- or four-byte lead
	a_limit_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(u8_q.limit != rpu8_pkg::LIM_NONE) |-> ((u8_q.pending == 2'd2) || (u8_q.pending == 2'd3)))
		else $error("continuation limit set without matching pending count");

endmodule

/* rtl/rpu8_utf8.sv */
module rpu8_utf8 (
	input  logic [7:0]          data,
	input  rpu8_pkg::u8_state_t cur,
	output rpu8_pkg::u8_state_t nxt,
	output logic                bad
);

	always_comb begin
		nxt = cur;
		bad = 1'b0;
		if (cur.pending != 2'd0) begin
			bad = (data & rpu8_pkg::CONT_MASK) != rpu8_pkg::CONT_TAG;
			case (cur.limit)
				rpu8_pkg::LIM_GE_A0: if (data < rpu8_pkg::BOUND_A0) bad = 1'b1;
				rpu8_pkg::LIM_LT_A0: if (data >= rpu8_pkg::BOUND_A0) bad = 1'b1;
				rpu8_pkg::LIM_GE_90: if (data < rpu8_pkg::BOUND_90) bad = 1'b1;
				rpu8_pkg::LIM_LT_90: if (data >= rpu8_pkg::BOUND_90) bad = 1'b1;
				default: ;
			endcase
			nxt.limit   = rpu8_pkg::LIM_NONE;
			nxt.pending = cur.pending - 2'd1;
		end else if (data <= rpu8_pkg::ASCII_MAX) begin
			// single byte, nothing to track
		end else if (data inside {[rpu8_pkg::LEAD2_MIN:rpu8_pkg::LEAD2_MAX]}) begin
			nxt.pending = 2'd1;
			nxt.limit   = rpu8_pkg::LIM_NONE;
		end else if (data inside {[rpu8_pkg::LEAD3_MIN:rpu8_pkg::LEAD3_MAX]}) begin
			nxt.pending = 2'd2;
			if (data == rpu8_pkg::LEAD3_MIN)
				nxt.limit = rpu8_pkg::LIM_GE_A0;
			else if (data == rpu8_pkg::LEAD3_SURR)
				nxt.limit = rpu8_pkg::LIM_LT_A0;
			else
				nxt.limit = rpu8_pkg::LIM_NONE;
		end else if (data inside {[rpu8_pkg::LEAD4_MIN:rpu8_pkg::LEAD4_MAX]}) begin
			nxt.pending = 2'd3;
			if (data == rpu8_pkg::LEAD4_MIN)
				nxt.limit = rpu8_pkg::LIM_GE_90;
			else if (data == rpu8_pkg::LEAD4_MAX)
				nxt.limit = rpu8_pkg::LIM_LT_90;
			else
				nxt.limit = rpu8_pkg::LIM_NONE;
		end else begin
			bad = 1'b1;
		end
	end

endmodule

/* rtl/rpu8_seg.sv */
module rpu8_seg (
	input  logic [7:0]           data,
	input  logic                 has_data,
	input  logic                 is_last,
	input  rpu8_pkg::seg_state_t cur,
	output rpu8_pkg::seg_state_t nxt,
	output logic                 bad
);

	rpu8_pkg::seg_state_t s;

	// empty, "." or ".." segment
	function automatic logic close_bad(input rpu8_pkg::seg_state_t st);
		close_bad = (st.len == 2'd0) || ((st.len <= 2'd2) && st.all_dots);
	endfunction

	always_comb begin
		s   = cur;
		bad = 1'b0;
		if (has_data) begin
			if ((data == rpu8_pkg::CHR_BACKSLASH) || (data == rpu8_pkg::CHR_NUL))
				bad = 1'b1;
			if (data == rpu8_pkg::CHR_SLASH) begin
				if (close_bad(s))
					bad = 1'b1;
				s.len      = 2'd0;
				s.all_dots = 1'b1;
			end else begin
				if (s.len != rpu8_pkg::SEG_LEN_MAX)
					s.len = s.len + 2'd1;
				if (data != rpu8_pkg::CHR_DOT)
					s.all_dots = 1'b0;
			end
		end
		// close the final segment at end of path
		if (is_last) begin
			if (close_bad(s))
				bad = 1'b1;
			s.len      = 2'd0;
			s.all_dots = 1'b1;
		end
		nxt = s;
	end

endmodule
